FILE: hw/rtl/hotp_pkg.sv
`default_nettype none
package hotp_pkg;

	localparam int KEY_MAX_BYTES_DEF = 20;
	localparam int WINDOW_MAX_DEF    = 255;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 64;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MID  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIGITS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 3'd5;

	// Item kinds.
	localparam logic [1:0] KIND_CHECK   = 2'd0;
	localparam logic [1:0] KIND_COMPUTE = 2'd1;
	localparam logic [1:0] KIND_LOAD    = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [29:0] otp_value;
		logic [63:0] counter_value;
	} in_item_t;

	typedef struct packed {
		logic        matched;
		logic [63:0] matched_counter;
		logic [29:0] otp_result;
		logic [63:0] next_counter;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       start_hash;  // begin HMAC of the working counter
		logic       load_cnt;    // working counter from item
		logic       load_stored; // working counter from stored counter
		logic       inc_cnt;     // advance working counter
		logic       set_stored;  // stored counter = item value
		logic       set_match;   // stored counter = working + 1
		logic       start_mod;   // begin modulo reduction
	} cmd_t;

	typedef struct packed {
		logic hash_done;
		logic mod_done;
		logic equal;
	} sts_t;

	// Powers of ten for the OTP modulus.
	function automatic logic [29:0] pow_ten(input logic [3:0] d);
		logic [29:0] r;
		unique case (d)
			4'd0: r = 30'd1;
			4'd1: r = 30'd10;
			4'd2: r = 30'd100;
			4'd3: r = 30'd1000;
			4'd4: r = 30'd10000;
			4'd5: r = 30'd100000;
			4'd6: r = 30'd1000000;
			4'd7: r = 30'd10000000;
			4'd8: r = 30'd100000000;
			default: r = 30'd1000000000;
		endcase
		return r;
	endfunction

	// SHA-1 round constant by round number.
	function automatic logic [31:0] sha_k(input logic [6:0] r);
		logic [31:0] k;
		priority if (r < 7'd20) k = 32'h5A827999;
		else if (r < 7'd40) k = 32'h6ED9EBA1;
		else if (r < 7'd60) k = 32'h8F1BBCDC;
		else k = 32'hCA62C1D6;
		return k;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/hotp_stream_if.sv
`default_nettype none
interface hotp_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/hotp_window_verifier.sv
`default_nettype none
// HOTP (RFC 4226, HMAC-SHA1) generator and window verifier. One transaction in
// gives one transaction out. A load sets the stored counter and presents its
// result; a compute runs four SHA-1 compressions on a one-round-per-cycle core,
// plus a bit-serial modulo; a check does the same for each window counter tried,
// up to the window setting (clamped to WINDOW_MAX) of them, and stops at the
// first match. One item is in work at a time; the result sits in an output
// register, and the next item is taken only once that register has been emptied.
module hotp_window_verifier #(
	parameter int KEY_MAX_BYTES = hotp_pkg::KEY_MAX_BYTES_DEF,
	parameter int WINDOW_MAX    = hotp_pkg::WINDOW_MAX_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [hotp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [hotp_pkg::CFG_DATA_W-1:0]  cfg_data,
	hotp_stream_if.sink                           in_ch,
	hotp_stream_if.source                         out_ch
);
	logic [63:0]  key_low_q, key_mid_q;
	logic [31:0]  key_high_q;
	logic [4:0]   key_len_q;
	logic [3:0]   digits_q;
	logic [7:0]   window_q;
	logic [159:0] key_all;
	hotp_pkg::in_item_t  item_q;
	hotp_pkg::out_item_t out_q;
	hotp_pkg::cmd_t cmd;
	hotp_pkg::sts_t sts;
	logic         out_valid_q, out_load, out_matched, acc;
	logic [63:0]  work_cnt, stored_cnt;
	logic [29:0]  otp;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_mid_q  <= '0;
			key_high_q <= '0;
			key_len_q  <= 5'd20;
			digits_q   <= 4'd6;
			window_q   <= 8'd10;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hotp_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data;
				hotp_pkg::REG_KEY_MID:  key_mid_q  <= cfg_data;
				hotp_pkg::REG_KEY_HIGH: key_high_q <= cfg_data[31:0];
				hotp_pkg::REG_KEY_LEN:  key_len_q  <= cfg_data[4:0];
				hotp_pkg::REG_DIGITS:   digits_q   <= cfg_data[3:0];
				hotp_pkg::REG_WINDOW:   window_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign key_all = {key_high_q, key_mid_q, key_low_q};
	assign acc = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk) begin
		if (acc) item_q <= in_ch.payload;
	end

	hotp_ctrl #(.WINDOW_MAX(WINDOW_MAX)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.kind(in_ch.payload.kind), .window(window_q), .cmd(cmd), .sts(sts),
		.out_load(out_load), .out_matched(out_matched), .out_free(!out_valid_q)
	);

	hotp_datapath #(.KEY_MAX_BYTES(KEY_MAX_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.item(acc ? in_ch.payload : item_q),
		.key(key_all[8*KEY_MAX_BYTES-1:0]), .key_len(key_len_q), .digits(digits_q),
		.work_cnt(work_cnt), .stored_cnt(stored_cnt), .otp(otp)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.matched         <= out_matched;
			out_q.matched_counter <= out_matched ? work_cnt : 64'd0;
			out_q.otp_result      <= (item_q.kind == hotp_pkg::KIND_COMPUTE) ? otp : 30'd0;
			out_q.next_counter    <= stored_cnt;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;
endmodule
`default_nettype wire

FILE: hw/rtl/hotp_sha1_core.sv
`default_nettype none
// One SHA-1 compression, one round per cycle, with a 16-word rolling schedule.
module hotp_sha1_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [159:0] h_in,
	input  wire logic [511:0] blk,
	output logic              done,
	output logic [159:0]      h_out
);
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [159:0] h_q;
	logic [31:0]  w_q [16];
	logic [6:0]   rnd_q;
	logic         busy_q;
	logic [31:0]  f, t, wn;

	// Round function and next schedule word.
	always_comb begin
		priority if (rnd_q < 7'd20) f = (b_q & c_q) | (~b_q & d_q);
		else if (rnd_q < 7'd40) f = b_q ^ c_q ^ d_q;
		else if (rnd_q < 7'd60) f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
		else f = b_q ^ c_q ^ d_q;
		t  = {a_q[26:0], a_q[31:27]} + f + e_q + hotp_pkg::sha_k(rnd_q) + w_q[0];
		wn = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		wn = {wn[30:0], wn[31]};
	end

	// Control of the round counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				if (rnd_q == 7'd79) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				rnd_q <= rnd_q + 7'd1;
			end
		end
	end

	// Working variables and message schedule.
	always_ff @(posedge clk) begin
		if (start) begin
			h_q <= h_in;
			{a_q, b_q, c_q, d_q, e_q} <= h_in;
			for (int i = 0; i < 16; i++) w_q[i] <= blk[511-32*i -: 32];
		end else if (busy_q) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t;
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
		end
	end

	assign h_out = {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
		h_q[63:32] + d_q, h_q[31:0] + e_q};
endmodule
`default_nettype wire

FILE: hw/rtl/hotp_datapath.sv
`default_nettype none
// HMAC sequencing over the SHA-1 core, truncation, modulo and counters.
module hotp_datapath #(
	parameter int KEY_MAX_BYTES = hotp_pkg::KEY_MAX_BYTES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire hotp_pkg::cmd_t       cmd,
	output hotp_pkg::sts_t            sts,
	input  wire hotp_pkg::in_item_t   item,
	input  wire logic [8*KEY_MAX_BYTES-1:0] key,
	input  wire logic [4:0]           key_len,
	input  wire logic [3:0]           digits,
	output logic [63:0]               work_cnt,
	output logic [63:0]               stored_cnt,
	output logic [29:0]               otp
);
	localparam logic [159:0] H_INIT =
		160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

	logic [63:0]  work_q, stored_q;
	logic [1:0]   phase_q;
	logic         hbusy_q, hdone_q, core_start, core_done;
	logic         hash_done_q;
	logic [159:0] h_in_q, h_out, inner_q;
	logic [511:0] blk;
	logic [511:0] kpad;
	logic [4:0]   klen;
	logic [7:0]   kb;
	logic [3:0]   off;
	logic [31:0]  code;
	logic [31:0]  rem_q;
	logic [4:0]   mstep_q;
	logic         mbusy_q, mdone_q;
	logic [59:0]  msub_q;
	logic [32:0]  diff;

	// Key padded to the block with zeros, clamped length.
	always_comb begin
		klen = (key_len > 5'(KEY_MAX_BYTES)) ? 5'(KEY_MAX_BYTES) : key_len;
		kpad = '0;
		for (int i = 0; i < KEY_MAX_BYTES; i++) begin
			kb = key[8*i +: 8];
			if (5'(i) < klen) kpad[511-8*i -: 8] = kb;
		end
	end

	// Block fed to the core for each of the four compressions.
	always_comb begin
		unique case (phase_q)
			2'd0: blk = kpad ^ {64{8'h36}};
			2'd1: blk = {work_q, 8'h80, 376'd0, 64'd576};
			2'd2: blk = kpad ^ {64{8'h5C}};
			default: blk = {inner_q, 8'h80, 280'd0, 64'd672};
		endcase
	end

	assign core_start = hbusy_q && hdone_q;

	hotp_sha1_core u_core (
		.clk(clk), .arst_n(arst_n), .start(core_start),
		.h_in(h_in_q), .blk(blk), .done(core_done), .h_out(h_out)
	);

	// Compression sequencing; hdone_q marks a pending core start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hbusy_q <= 1'b0;
			hdone_q <= 1'b0;
			phase_q <= 2'd0;
			hash_done_q <= 1'b0;
		end else begin
			hash_done_q <= 1'b0;
			hdone_q <= 1'b0;
			if (cmd.start_hash) begin
				hbusy_q <= 1'b1;
				hdone_q <= 1'b1;
				phase_q <= 2'd0;
			end else if (core_done) begin
				phase_q <= phase_q + 2'd1;
				if (phase_q == 2'd3) begin
					hbusy_q <= 1'b0;
					hash_done_q <= 1'b1;
				end else begin
					hdone_q <= 1'b1;
				end
			end
		end
	end

	// inner_q holds the inner digest, and after the last compression the final one.
	always_ff @(posedge clk) begin
		if (cmd.start_hash) h_in_q <= H_INIT;
		else if (core_done) begin
			unique case (phase_q)
				2'd0, 2'd2: h_in_q <= h_out;
				2'd1: begin
					inner_q <= h_out;
					h_in_q  <= H_INIT;
				end
				default: inner_q <= h_out;
			endcase
		end
	end

	// Dynamic truncation from the final digest.
	always_comb begin
		off  = inner_q[3:0];
		code = inner_q[159-8*off -: 32];
		code[31] = 1'b0;
	end

	// Restoring modulo: subtract the modulus shifted down one bit per cycle.
	assign diff = {1'b0, rem_q} - {2'b0, msub_q[30:0]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
			mstep_q <= '0;
		end else begin
			mdone_q <= 1'b0;
			if (cmd.start_mod) begin
				mbusy_q <= 1'b1;
				mstep_q <= '0;
			end else if (mbusy_q) begin
				mstep_q <= mstep_q + 5'd1;
				if (mstep_q == 5'd30) begin
					mbusy_q <= 1'b0;
					mdone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_mod) begin
			rem_q  <= code;
			msub_q <= {hotp_pkg::pow_ten((digits > 4'd9) ? 4'd9 : digits), 30'd0};
		end else if (mbusy_q) begin
			if (msub_q[59:31] == 29'd0 && !diff[32]) rem_q <= diff[31:0];
			msub_q <= {1'b0, msub_q[59:1]};
		end
	end

	// Counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) stored_q <= '0;
		else if (cmd.set_stored) stored_q <= item.counter_value;
		else if (cmd.set_match) stored_q <= work_q + 64'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_cnt) work_q <= item.counter_value;
		else if (cmd.load_stored) work_q <= stored_q;
		else if (cmd.inc_cnt) work_q <= work_q + 64'd1;
	end

	assign sts.hash_done = hash_done_q;
	assign sts.mod_done  = mdone_q;
	assign sts.equal     = (rem_q[29:0] == item.otp_value) && (rem_q[31:30] == 2'b0);
	assign work_cnt      = work_q;
	assign stored_cnt    = stored_q;
	assign otp           = rem_q[29:0];
endmodule
`default_nettype wire

FILE: hw/rtl/hotp_ctrl.sv
`default_nettype none
// Item sequencer: load, compute, and the window search of a check.
module hotp_ctrl #(
	parameter int WINDOW_MAX = hotp_pkg::WINDOW_MAX_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [1:0]     kind,
	input  wire logic [7:0]     window,
	output hotp_pkg::cmd_t      cmd,
	input  wire hotp_pkg::sts_t sts,
	output logic                out_load,
	output logic                out_matched,
	input  wire logic           out_free
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_HASH = 5'b00010,
		ST_MOD  = 5'b00100,
		ST_EVAL = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t     state_q;
	logic [1:0] kind_q;
	logic [7:0] left_q, win;
	logic       acc;

	// A result still on its way into the output register also blocks the input.
	assign win      = (window > 8'(WINDOW_MAX)) ? 8'(WINDOW_MAX) : window;
	assign in_ready = (state_q == ST_IDLE) && out_free && !out_load;
	assign acc      = in_valid && in_ready;

	// Next-state logic with command outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= hotp_pkg::KIND_LOAD;
			left_q      <= '0;
			cmd         <= '0;
			out_load    <= 1'b0;
			out_matched <= 1'b0;
		end else begin
			cmd      <= '0;
			out_load <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (acc) begin
					kind_q      <= kind;
					out_matched <= 1'b0;
					left_q      <= win;
					if (kind == hotp_pkg::KIND_COMPUTE) begin
						cmd.load_cnt <= 1'b1;
						state_q <= ST_OUT;
					end else if (kind == hotp_pkg::KIND_CHECK) begin
						cmd.load_stored <= 1'b1;
						state_q <= ST_EVAL;
					end else begin
						cmd.set_stored <= (kind == hotp_pkg::KIND_LOAD);
						state_q <= ST_OUT;
					end
				end
				ST_HASH: if (sts.hash_done) begin
					cmd.start_mod <= 1'b1;
					state_q <= ST_MOD;
				end
				ST_MOD: if (sts.mod_done) begin
					if (kind_q == hotp_pkg::KIND_COMPUTE) begin
						out_load <= 1'b1;
						state_q  <= ST_IDLE;
					end else if (sts.equal) begin
						cmd.set_match <= 1'b1;
						out_matched   <= 1'b1;
						state_q       <= ST_OUT;
						kind_q        <= hotp_pkg::KIND_LOAD;
					end else begin
						cmd.inc_cnt <= 1'b1;
						state_q     <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (left_q == 8'd0) begin
						out_load <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						left_q <= left_q - 8'd1;
						cmd.start_hash <= 1'b1;
						state_q <= ST_HASH;
					end
				end
				ST_OUT: begin
					if (kind_q == hotp_pkg::KIND_COMPUTE) begin
						cmd.start_hash <= 1'b1;
						state_q <= ST_HASH;
					end else begin
						out_load <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/hotp_checker.sv
`default_nettype none
// Port-level checks on the verifier.
module hotp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_matched,
	input wire logic [63:0] out_mcnt,
	input wire logic [29:0] out_otp
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("second item taken");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("item taken with result pending");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_matched |-> out_otp == 30'd0) else $error("otp on check");
	a_mc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_matched |-> out_mcnt == 64'd0) else $error("stray counter");
endmodule

bind hotp_window_verifier hotp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_matched(out_ch.payload.matched), .out_mcnt(out_ch.payload.matched_counter),
	.out_otp(out_ch.payload.otp_result)
);
`default_nettype wire
